FILE: src/cpcp_pkg.sv
// ---------------------------------------------------------------------------
// cpcp_pkg: shared types and constants of the closest pair center pruner
// Function codes, register indexes, port widths, state and status types.
// ---------------------------------------------------------------------------
package cpcp_pkg;

   // Fixed field widths of the item ports and the configuration registers
   localparam int FUNC_W      = 2;
   localparam int NODE_PORT_W = 6;
   localparam int DIST_PORT_W = 32;
   localparam int COUNT_W     = 8;
   localparam int COIN_W      = 64;
   localparam int CFG_N_W     = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Result cap per run
   localparam int RESULT_CAP  = 64;
   localparam int EMIT_W      = $clog2(RESULT_CAP);
   localparam int STEP_W      = $clog2(COIN_W);

   // Function codes of an input item
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIST  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLUSTER_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD     = 2'd2;

   // Register reset values
   localparam logic [CFG_N_W-1:0]    NODE_COUNT_RST    = 7'd64;
   localparam logic [CFG_N_W-1:0]    CLUSTER_COUNT_RST = 7'd1;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RST     = 8'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Status of one pair search
   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

FILE: src/cpcp_ram.sv
// ---------------------------------------------------------------------------
// cpcp_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module cpcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cpcp_pair_scan.sv
// ---------------------------------------------------------------------------
// cpcp_pair_scan: smallest off-diagonal distance among live nodes
// Sweeps columns then rows through the distance memory, one entry a cycle.
// ---------------------------------------------------------------------------
module cpcp_pair_scan #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [$clog2(MAX_NODES+1)-1:0]            node_limit,
   input  logic [MAX_NODES-1:0]                      alive,
   output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]    rd_addr,
   input  logic [DIST_BITS-1:0]                      rd_data,
   output logic [$clog2(MAX_NODES)-1:0]              best_row,
   output logic [$clog2(MAX_NODES)-1:0]              best_col,
   output cpcp_pkg::scan_stat_type                   status
);
   import cpcp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES+1);
   localparam int ADDR_W = $clog2(MAX_NODES*MAX_NODES);

   logic              active_ff, active_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic              pv_ff, pv_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  prow_ff, prow_in;
   logic [IDX_W-1:0]  pcol_ff, pcol_in;
   logic              found_ff, found_in;
   logic              done_ff, done_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  brow_ff, brow_in;
   logic [IDX_W-1:0]  bcol_ff, bcol_in;

   logic [CNT_W-1:0]  last_idx;
   logic              col_last;
   logic              row_last;

   assign last_idx = node_limit - CNT_W'(1);
   assign col_last = (CNT_W'(col_ff) == last_idx);
   assign row_last = (CNT_W'(row_ff) == last_idx);
   assign rd_addr  = ADDR_W'(row_ff) * ADDR_W'(MAX_NODES) + ADDR_W'(col_ff);

   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pv_in     = 1'b0;
      pend_in   = 1'b0;
      prow_in   = row_ff;
      pcol_in   = col_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      brow_in   = brow_ff;
      bcol_in   = bcol_ff;
      done_in   = pend_ff;

      // compare stage: entry read last cycle
      if (pv_ff && (!found_ff || rd_data < best_ff)) begin
         found_in = 1'b1;
         best_in  = rd_data;
         brow_in  = prow_ff;
         bcol_in  = pcol_ff;
      end

      // issue stage: skip dead columns without reading their entries
      if (active_ff) begin
         if (alive[col_ff]) begin
            pv_in   = alive[row_ff] && (row_ff != col_ff);
            pend_in = col_last && row_last;
            if (row_last) begin
               row_in = '0;
               col_in = col_ff + IDX_W'(1);
            end else begin
               row_in = row_ff + IDX_W'(1);
            end
         end else begin
            pend_in = col_last;
            row_in  = '0;
            col_in  = col_ff + IDX_W'(1);
         end
         if (pend_in) begin
            active_in = 1'b0;
         end
      end

      if (start) begin
         active_in = 1'b1;
         col_in    = '0;
         row_in    = '0;
         found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pv_ff     <= 1'b0;
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         pv_ff     <= pv_in;
         pend_ff   <= pend_in;
         done_ff   <= done_in;
         found_ff  <= found_in;
      end
      col_ff  <= col_in;
      row_ff  <= row_in;
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      best_ff <= best_in;
      brow_ff <= brow_in;
      bcol_ff <= bcol_in;
   end

   assign best_row     = brow_ff;
   assign best_col     = bcol_ff;
   assign status.done  = done_ff;
   assign status.found = found_ff;

endmodule

FILE: src/closest_pair_center_pruner.sv
// ---------------------------------------------------------------------------
// closest_pair_center_pruner: cluster center selection by closest-pair pruning
// Loads neighbor counts and a distance matrix, then prunes nodes on a run item.
// ---------------------------------------------------------------------------
// Load items (count or distance writes) are taken one per cycle while idle and
// produce no result. A run item holds the input until its last result is
// queued: a pass over the count memory first marks the important nodes,
// then each merge step sweeps the distance memory through its single read
// port, one entry a cycle, skipping each dead column without reading it.
// Survivors leave in ascending index order through an output register, so
// the block goes back to taking items while the last result still waits.
// Memories hold whatever was written; nothing is cleared after reset, and
// every entry a run reads must have been loaded first.
module closest_pair_center_pruner #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cpcp_pkg::FUNC_W-1:0]        req_func,
   input  logic [cpcp_pkg::NODE_PORT_W-1:0]   req_row_node,
   input  logic [cpcp_pkg::NODE_PORT_W-1:0]   req_col_node,
   input  logic [cpcp_pkg::DIST_PORT_W-1:0]   req_distance,
   input  logic [cpcp_pkg::COUNT_W-1:0]       req_neighbor_count,
   input  logic [cpcp_pkg::COIN_W-1:0]        req_coin_bits,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cpcp_pkg::NODE_PORT_W-1:0]   rsp_center_index,
   output logic                               rsp_empty_set,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_write_en,
   input  logic [cpcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpcp_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import cpcp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES+1);
   localparam int ADDR_W = $clog2(MAX_NODES*MAX_NODES);
   localparam int CMP_W  = (CNT_W > CFG_N_W) ? CNT_W : CFG_N_W;

   // configuration registers
   logic [CFG_N_W-1:0]    node_count_ff;
   logic [CFG_N_W-1:0]    cluster_count_ff;
   logic [CSR_DATA_W-1:0] threshold_ff;

   // control state
   state_type             state_ff, state_in;
   logic [MAX_NODES-1:0]  alive_ff, alive_in;
   logic [CNT_W-1:0]      remaining_ff, remaining_in;
   logic [CNT_W-1:0]      nodes_ff, nodes_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COIN_W-1:0]     coins_ff, coins_in;
   logic [IDX_W-1:0]      init_idx_ff, init_idx_in;
   logic                  init_issue_ff, init_issue_in;
   logic                  ip_valid_ff, ip_valid_in;
   logic [IDX_W-1:0]      ip_idx_ff, ip_idx_in;
   logic [IDX_W-1:0]      emit_idx_ff, emit_idx_in;
   logic [EMIT_W-1:0]     emit_cnt_ff, emit_cnt_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NODE_PORT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_last_ff, rsp_last_in;

   // memory ports
   logic                   req_fire;
   logic                   row_in_range;
   logic                   col_in_range;
   logic                   cnt_wr_en;
   logic                   dist_wr_en;
   logic [IDX_W-1:0]       wr_row;
   logic [IDX_W-1:0]       wr_col;
   logic [ADDR_W-1:0]      dist_wr_addr;
   logic [DIST_BITS-1:0]   dist_wr_data;
   logic [ADDR_W-1:0]      dist_rd_addr;
   logic [DIST_BITS-1:0]   dist_rd_data;
   logic [COUNT_W-1:0]     cnt_rd_data;

   // pair search
   logic                   scan_start;
   logic [IDX_W-1:0]       best_row;
   logic [IDX_W-1:0]       best_col;
   scan_stat_type          scan_stat;

   logic                   slot_free;
   logic                   merge_more;
   logic                   emit_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // drop writes beyond the store
   assign row_in_range = (32'(req_row_node) < MAX_NODES);
   assign col_in_range = (32'(req_col_node) < MAX_NODES);
   assign wr_row       = IDX_W'(req_row_node);
   assign wr_col       = IDX_W'(req_col_node);
   assign cnt_wr_en    = req_fire && (req_func == FUNC_COUNT) && row_in_range;
   assign dist_wr_en   = req_fire && (req_func == FUNC_DIST) && row_in_range && col_in_range;
   assign dist_wr_addr = ADDR_W'(wr_row) * ADDR_W'(MAX_NODES) + ADDR_W'(wr_col);
   assign dist_wr_data = DIST_BITS'(req_distance);

   cpcp_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_NODES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (wr_row),
      .wr_data (req_neighbor_count),
      .rd_addr (init_idx_ff),
      .rd_data (cnt_rd_data)
   );

   cpcp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_NODES*MAX_NODES)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

   cpcp_pair_scan #(
      .MAX_NODES (MAX_NODES),
      .DIST_BITS (DIST_BITS)
   ) u_pair_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .node_limit (nodes_ff),
      .alive      (alive_ff),
      .rd_addr    (dist_rd_addr),
      .rd_data    (dist_rd_data),
      .best_row   (best_row),
      .best_col   (best_col),
      .status     (scan_stat)
   );

   // configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff    <= NODE_COUNT_RST;
         cluster_count_ff <= CLUSTER_COUNT_RST;
         threshold_ff     <= THRESHOLD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_NODE_COUNT:    node_count_ff    <= CFG_N_W'(csr_write_data);
            REG_CLUSTER_COUNT: cluster_count_ff <= CFG_N_W'(csr_write_data);
            REG_THRESHOLD:     threshold_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   // keep merging while at least two nodes remain and more than the target
   assign merge_more = (remaining_ff >= CNT_W'(2)) &&
                       (CMP_W'(remaining_ff) > CMP_W'(cluster_count_ff));
   // last survivor, or the result cap reached
   assign emit_last  = ((CMP_W'(emit_cnt_ff) + CMP_W'(1)) == CMP_W'(remaining_ff)) ||
                       (emit_cnt_ff == EMIT_W'(RESULT_CAP-1));

   always_comb begin
      state_in      = state_ff;
      alive_in      = alive_ff;
      remaining_in  = remaining_ff;
      nodes_in      = nodes_ff;
      step_in       = step_ff;
      coins_in      = coins_ff;
      init_idx_in   = init_idx_ff;
      init_issue_in = 1'b0;
      ip_valid_in   = 1'b0;
      ip_idx_in     = init_idx_ff;
      emit_idx_in   = emit_idx_ff;
      emit_cnt_in   = emit_cnt_ff;
      scan_start    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == FUNC_RUN)) begin
               // clamp the node count and start from an empty mask
               if (32'(node_count_ff) > MAX_NODES) begin
                  nodes_in = CNT_W'(MAX_NODES);
               end else begin
                  nodes_in = CNT_W'(node_count_ff);
               end
               alive_in      = '0;
               remaining_in  = '0;
               step_in       = '0;
               emit_idx_in   = '0;
               emit_cnt_in   = '0;
               init_idx_in   = '0;
               coins_in      = req_coin_bits;
               init_issue_in = (nodes_in != '0);
               state_in      = (nodes_in != '0) ? ST_INIT : ST_CHECK;
            end
         end
         ST_INIT: begin
            // read counts of nodes 0..n-1, mark the important ones
            if (init_issue_ff) begin
               ip_valid_in = 1'b1;
               if (CNT_W'(init_idx_ff) != nodes_ff - CNT_W'(1)) begin
                  init_issue_in = 1'b1;
                  init_idx_in   = init_idx_ff + IDX_W'(1);
               end
            end
            if (ip_valid_ff && (cnt_rd_data >= threshold_ff)) begin
               alive_in[ip_idx_ff] = 1'b1;
               remaining_in        = remaining_ff + CNT_W'(1);
            end
            if (!init_issue_ff && !ip_valid_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (merge_more) begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               if (scan_stat.found) begin
                  // coin 1 drops the row node, coin 0 the column node
                  if (coins_ff[step_ff]) begin
                     alive_in[best_row] = 1'b0;
                  end else begin
                     alive_in[best_col] = 1'b0;
                  end
                  remaining_in = remaining_ff - CNT_W'(1);
                  step_in      = step_ff + STEP_W'(1);
                  state_in     = ST_CHECK;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (remaining_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_empty_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (alive_ff[emit_idx_ff]) begin
               // hold on a survivor until the output register frees up
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = NODE_PORT_W'(emit_idx_ff);
                  rsp_empty_in = 1'b0;
                  rsp_last_in  = emit_last;
                  emit_cnt_in  = emit_cnt_ff + EMIT_W'(1);
                  emit_idx_in  = emit_idx_ff + IDX_W'(1);
                  if (emit_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               emit_idx_in = emit_idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         alive_ff      <= '0;
         remaining_ff  <= '0;
         init_issue_ff <= 1'b0;
         ip_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alive_ff      <= alive_in;
         remaining_ff  <= remaining_in;
         init_issue_ff <= init_issue_in;
         ip_valid_ff   <= ip_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      nodes_ff     <= nodes_in;
      step_ff      <= step_in;
      coins_ff     <= coins_in;
      init_idx_ff  <= init_idx_in;
      ip_idx_ff    <= ip_idx_in;
      emit_idx_ff  <= emit_idx_in;
      emit_cnt_ff  <= emit_cnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_center_index = rsp_index_ff;
   assign rsp_empty_set    = rsp_empty_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // live count tracks the mask between merge steps
   a_remaining_matches_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ($countones(alive_ff) == 32'(remaining_ff)))
      else $error("remaining count differs from live mask");

   // a found pair is two distinct live nodes
   a_pair_is_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_stat.done && scan_stat.found) |->
      (alive_ff[best_row] && alive_ff[best_col] && (best_row != best_col)))
      else $error("closest pair is not two distinct live nodes");

   // a run item leaves idle
   a_run_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func == FUNC_RUN)) |=> (state_ff != ST_IDLE))
      else $error("run item did not start a run");

   // an empty result closes the run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> rsp_last_ff)
      else $error("empty result not flagged last");

   // no merge step runs with fewer than two live nodes
   a_scan_needs_two: assert property (@(posedge clock) disable iff (reset)
      scan_start |-> (remaining_ff >= CNT_W'(2)))
      else $error("pair search started with fewer than two nodes");
`endif

endmodule
